// ----- sv/nearest_tag_distance_table_macros.svh -----
// Assertion macros for the nearest tag distance table.
// Included by the top level; no other dependencies.
`ifndef NEAREST_TAG_DISTANCE_TABLE_MACROS_SVH
`define NEAREST_TAG_DISTANCE_TABLE_MACROS_SVH
`ifndef NO_ASSERTIONS
`define NTDT_ASSERT_IMPLY(label, clk, rst, cond, prop) \
   label: assert property (@(posedge clk) disable iff (rst) (cond) |-> (prop)) \
      else $error("ntdt: implication check failed");
`define NTDT_ASSERT_NEXT(label, clk, rst, cond, prop) \
   label: assert property (@(posedge clk) disable iff (rst) (cond) |=> (prop)) \
      else $error("ntdt: next-cycle check failed");
`else
`define NTDT_ASSERT_IMPLY(label, clk, rst, cond, prop)
`define NTDT_ASSERT_NEXT(label, clk, rst, cond, prop)
`endif
`endif

// ----- sv/ntdt_pkg.sv -----
// Shared constants, types and operation codes for the nearest tag distance table.
// No dependencies.
package ntdt_pkg;

   localparam int TABLE_ENTRIES  = 16;
   localparam int ID_BITS        = 16;
   localparam int FIELD_ID_BITS  = 16;
   localparam int DIST_BITS      = 16;
   localparam int LINK_BITS      = 10;
   localparam int KIND_BITS      = 2;
   localparam int OUT_COUNT_BITS = 5;
   localparam int COUNT_BITS     = $clog2(TABLE_ENTRIES + 1);
   localparam int GROUP_SIZE     = 4;
   localparam int GROUPS         = (TABLE_ENTRIES + GROUP_SIZE - 1) / GROUP_SIZE;

   localparam logic [DIST_BITS-1:0] MAX_DIST_RESET = 16'd2560;

   localparam logic [KIND_BITS-1:0] KIND_MERGE       = 2'd0;
   localparam logic [KIND_BITS-1:0] KIND_SET_ZERO    = 2'd1;
   localparam logic [KIND_BITS-1:0] KIND_CLEAR       = 2'd2;
   localparam logic [KIND_BITS-1:0] KIND_REMOVE_ZERO = 2'd3;

   typedef logic [DIST_BITS-1:0] dist_type;
   typedef logic [ID_BITS-1:0]   id_type;

   typedef struct packed {
      logic capture;
      logic update;
      logic reduce;
      logic finish;
   } cmd_type;

endpackage

// ----- sv/ntdt_ctrl.sv -----
// Sequencer for the nearest tag distance table: accept, update, reduce, finish.
// Depends on ntdt_pkg; drives the handshakes and the datapath commands.
module ntdt_ctrl (
   input  logic              clock,
   input  logic              reset,
   input  logic              req_valid,
   output logic              req_stall,
   output logic              rsp_valid,
   input  logic              rsp_stall,
   output ntdt_pkg::cmd_type cmd
);

   localparam logic [1:0] ST_IDLE   = 2'd0;
   localparam logic [1:0] ST_UPDATE = 2'd1;
   localparam logic [1:0] ST_REDUCE = 2'd2;
   localparam logic [1:0] ST_FINISH = 2'd3;

   logic [1:0] state_ff, state_in;
   logic       rsp_valid_ff, rsp_valid_in;
   logic       out_free;

   assign out_free  = !rsp_valid_ff || !rsp_stall;
   assign req_stall = (state_ff != ST_IDLE);
   assign rsp_valid = rsp_valid_ff;

   always_comb begin
      state_in     = state_ff;
      cmd          = '0;
      rsp_valid_in = rsp_valid_ff && rsp_stall;
      case (state_ff)
         ST_IDLE: begin
            if (req_valid) begin
               cmd.capture = 1'b1;
               state_in    = ST_UPDATE;
            end
         end
         ST_UPDATE: begin
            cmd.update = 1'b1;
            state_in   = ST_REDUCE;
         end
         ST_REDUCE: begin
            cmd.reduce = 1'b1;
            state_in   = ST_FINISH;
         end
         ST_FINISH: begin
            if (out_free) begin
               cmd.finish   = 1'b1;
               rsp_valid_in = 1'b1;
               state_in     = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

endmodule

// ----- sv/ntdt_datapath.sv -----
// Slot table, update logic, grouped minimum reduction and result registers.
// Depends on ntdt_pkg; steered by commands from ntdt_ctrl.
module ntdt_datapath (
   input  logic                                    clock,
   input  logic                                    reset,
   input  ntdt_pkg::cmd_type                       cmd,
   input  logic                                    csr_wr_en,
   input  logic [ntdt_pkg::DIST_BITS-1:0]          csr_wr_data,
   input  logic [ntdt_pkg::KIND_BITS-1:0]          req_kind,
   input  logic [ntdt_pkg::FIELD_ID_BITS-1:0]      req_bubble_id,
   input  logic [ntdt_pkg::DIST_BITS-1:0]          req_neighbor_distance,
   input  logic [ntdt_pkg::LINK_BITS-1:0]          req_link_distance,
   input  logic [ntdt_pkg::FIELD_ID_BITS-1:0]      req_query_id,
   output logic [ntdt_pkg::DIST_BITS-1:0]          rsp_nearest_distance,
   output logic                                    rsp_insert_dropped,
   output logic [ntdt_pkg::OUT_COUNT_BITS-1:0]     rsp_entry_count
);

   localparam int N = ntdt_pkg::TABLE_ENTRIES;

   ntdt_pkg::dist_type                     max_dist_ff;
   logic [ntdt_pkg::KIND_BITS-1:0]         kind_ff;
   ntdt_pkg::id_type                       id_ff;
   ntdt_pkg::id_type                       qid_ff;
   ntdt_pkg::dist_type                     ndist_ff;
   logic [ntdt_pkg::LINK_BITS-1:0]         ldist_ff;

   logic [N-1:0]                           slot_valid_ff, slot_valid_in;
   ntdt_pkg::id_type                       slot_id_ff [N];
   ntdt_pkg::dist_type                     slot_dist_ff [N];

   logic [N-1:0]                           hit, free_oh, dist_we, ins_we, kill, zero_dist;
   logic                                   hit_any, free_any;
   ntdt_pkg::dist_type                     hit_dist, sum_sat, wr_dist;
   logic [ntdt_pkg::DIST_BITS:0]           sum_wide;
   logic                                   dropped_ff, dropped_in;

   logic [N-1:0]                           elig;
   ntdt_pkg::dist_type                     grp_min_ff [ntdt_pkg::GROUPS];
   ntdt_pkg::dist_type                     grp_min_in [ntdt_pkg::GROUPS];
   logic [ntdt_pkg::COUNT_BITS-1:0]        count_ff, count_in;

   ntdt_pkg::dist_type                     near_in, near_ff;
   logic                                   out_drop_ff;
   logic [ntdt_pkg::COUNT_BITS-1:0]        out_count_ff;

   // config register
   always_ff @(posedge clock) begin
      if (reset) begin
         max_dist_ff <= ntdt_pkg::MAX_DIST_RESET;
      end else if (csr_wr_en) begin
         max_dist_ff <= csr_wr_data;
      end
   end

   // item capture
   always_ff @(posedge clock) begin
      if (cmd.capture) begin
         kind_ff  <= req_kind;
         id_ff    <= ntdt_pkg::ID_BITS'(req_bubble_id);
         qid_ff   <= ntdt_pkg::ID_BITS'(req_query_id);
         ndist_ff <= req_neighbor_distance;
         ldist_ff <= req_link_distance;
      end
   end

   // lookup, free slot and saturating sum
   always_comb begin
      for (int i = 0; i < N; i++) begin
         hit[i]       = slot_valid_ff[i] && (slot_id_ff[i] == id_ff);
         zero_dist[i] = slot_valid_ff[i] && (slot_dist_ff[i] == '0);
      end
      hit_any  = |hit;
      hit_dist = '0;
      for (int i = 0; i < N; i++) begin
         hit_dist = hit_dist | (slot_dist_ff[i] & {ntdt_pkg::DIST_BITS{hit[i]}});
      end
      free_oh  = ~slot_valid_ff & (slot_valid_ff + N'(1));
      free_any = ~&slot_valid_ff;
      sum_wide = {1'b0, ndist_ff} + (ntdt_pkg::DIST_BITS + 1)'(ldist_ff);
      sum_sat  = sum_wide[ntdt_pkg::DIST_BITS] ? '1 : sum_wide[ntdt_pkg::DIST_BITS-1:0];
   end

   always_comb begin
      dist_we    = '0;
      ins_we     = '0;
      kill       = '0;
      wr_dist    = sum_sat;
      dropped_in = 1'b0;
      case (kind_ff)
         ntdt_pkg::KIND_MERGE: begin
            if (hit_any) begin
               if (hit_dist > sum_sat) begin
                  dist_we = hit;
               end
            end else if (sum_sat < max_dist_ff) begin
               if (free_any) begin
                  ins_we = free_oh;
               end else begin
                  dropped_in = 1'b1;
               end
            end
         end
         ntdt_pkg::KIND_SET_ZERO: begin
            wr_dist = '0;
            if (hit_any) begin
               dist_we = hit;
            end else if (free_any) begin
               ins_we = free_oh;
            end else begin
               dropped_in = 1'b1;
            end
         end
         ntdt_pkg::KIND_CLEAR: begin
            kill = '1;
         end
         ntdt_pkg::KIND_REMOVE_ZERO: begin
            kill = zero_dist;
         end
         default: begin
            kill = '0;
         end
      endcase
      slot_valid_in = (slot_valid_ff & ~kill) | ins_we;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         slot_valid_ff <= '0;
      end else if (cmd.update) begin
         slot_valid_ff <= slot_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.update) begin
         dropped_ff <= dropped_in;
         for (int i = 0; i < N; i++) begin
            if (ins_we[i]) begin
               slot_id_ff[i] <= id_ff;
            end
            if (ins_we[i] || dist_we[i]) begin
               slot_dist_ff[i] <= wr_dist;
            end
         end
      end
   end

   // per-group minimum and entry count
   always_comb begin
      for (int i = 0; i < N; i++) begin
         elig[i] = slot_valid_ff[i] && (slot_id_ff[i] != qid_ff);
      end
      for (int g = 0; g < ntdt_pkg::GROUPS; g++) begin
         grp_min_in[g] = '1;
         for (int k = 0; k < ntdt_pkg::GROUP_SIZE; k++) begin
            if (g * ntdt_pkg::GROUP_SIZE + k < N) begin
               if (elig[g * ntdt_pkg::GROUP_SIZE + k] &&
                   slot_dist_ff[g * ntdt_pkg::GROUP_SIZE + k] < grp_min_in[g]) begin
                  grp_min_in[g] = slot_dist_ff[g * ntdt_pkg::GROUP_SIZE + k];
               end
            end
         end
      end
      count_in = '0;
      for (int i = 0; i < N; i++) begin
         count_in = count_in + ntdt_pkg::COUNT_BITS'(slot_valid_ff[i]);
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.reduce) begin
         grp_min_ff <= grp_min_in;
         count_ff   <= count_in;
      end
   end

   // final minimum, bounded by the search limit
   always_comb begin
      near_in = max_dist_ff;
      for (int g = 0; g < ntdt_pkg::GROUPS; g++) begin
         if (grp_min_ff[g] < near_in) begin
            near_in = grp_min_ff[g];
         end
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.finish) begin
         near_ff      <= near_in;
         out_drop_ff  <= dropped_ff;
         out_count_ff <= count_ff;
      end
   end

   assign rsp_nearest_distance = near_ff;
   assign rsp_insert_dropped   = out_drop_ff;
   assign rsp_entry_count      = ntdt_pkg::OUT_COUNT_BITS'(out_count_ff);

endmodule

// ----- sv/nearest_tag_distance_table.sv -----
// Top level of the nearest tag distance table: sequencer plus datapath.
// Depends on ntdt_pkg, ntdt_ctrl, ntdt_datapath and the assertion macro header.
//
//   channel | ports                         | direction
//   --------+-------------------------------+----------
//   request | req_valid, req_stall, req_*   | in
//   result  | rsp_valid, rsp_stall, rsp_*   | out
//   config  | csr_wr_en, csr_wr_data        | in
//
// Each item passes four steps: accept, table update, grouped minimum, final
// minimum into the result register. The final step waits while an earlier result
// is still held under rsp_stall; req_stall is high from accept until that step.
// Synchronous reset empties the table and sets max_distance to 2560 (10.0 Q8.8).
`include "nearest_tag_distance_table_macros.svh"
module nearest_tag_distance_table (
   input  logic                                    clock,
   input  logic                                    reset,
   input  logic                                    req_valid,
   output logic                                    req_stall,
   input  logic [ntdt_pkg::KIND_BITS-1:0]          req_kind,
   input  logic [ntdt_pkg::FIELD_ID_BITS-1:0]      req_bubble_id,
   input  logic [ntdt_pkg::DIST_BITS-1:0]          req_neighbor_distance,
   input  logic [ntdt_pkg::LINK_BITS-1:0]          req_link_distance,
   input  logic [ntdt_pkg::FIELD_ID_BITS-1:0]      req_query_id,
   output logic                                    rsp_valid,
   input  logic                                    rsp_stall,
   output logic [ntdt_pkg::DIST_BITS-1:0]          rsp_nearest_distance,
   output logic                                    rsp_insert_dropped,
   output logic [ntdt_pkg::OUT_COUNT_BITS-1:0]     rsp_entry_count,
   input  logic                                    csr_wr_en,
   input  logic [ntdt_pkg::DIST_BITS-1:0]          csr_wr_data
);

   ntdt_pkg::cmd_type cmd;

   ntdt_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_stall (req_stall),
      .rsp_valid (rsp_valid),
      .rsp_stall (rsp_stall),
      .cmd       (cmd)
   );

   ntdt_datapath u_datapath (
      .clock                 (clock),
      .reset                 (reset),
      .cmd                   (cmd),
      .csr_wr_en             (csr_wr_en),
      .csr_wr_data           (csr_wr_data),
      .req_kind              (req_kind),
      .req_bubble_id         (req_bubble_id),
      .req_neighbor_distance (req_neighbor_distance),
      .req_link_distance     (req_link_distance),
      .req_query_id          (req_query_id),
      .rsp_nearest_distance  (rsp_nearest_distance),
      .rsp_insert_dropped    (rsp_insert_dropped),
      .rsp_entry_count       (rsp_entry_count)
   );

   `NTDT_ASSERT_NEXT(a_busy_after_accept, clock, reset, req_valid && !req_stall, req_stall)
   `NTDT_ASSERT_IMPLY(a_drop_only_when_full, clock, reset, rsp_valid && rsp_insert_dropped, rsp_entry_count == ntdt_pkg::OUT_COUNT_BITS'(ntdt_pkg::TABLE_ENTRIES))
   `NTDT_ASSERT_IMPLY(a_one_item_in_flight, clock, reset, cmd.update || cmd.reduce || cmd.finish, req_stall && !cmd.capture)

endmodule
